// ===== rtl/core/ses_pkg.sv =====
// Shared types and constants for the SCAN elevator scheduler.
// No dependencies; every other file in rtl/core imports this package.
`timescale 1ns / 1ps

package ses_pkg;

    localparam int FLOORS  = 16;
    localparam int IDX_W   = $clog2(FLOORS);
    localparam int FLOOR_W = 5;
    localparam int CNT_W   = 4;
    localparam int TICK_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 5;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_CAPACITY    = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_START_FLOOR = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_TOP_FLOOR   = 2'd2;

    localparam logic [CNT_W-1:0]   RST_CAPACITY    = 4'd4;
    localparam logic [FLOOR_W-1:0] RST_START_FLOOR = 5'd1;
    localparam logic [FLOOR_W-1:0] RST_TOP_FLOOR   = 5'd10;
    localparam logic [FLOOR_W-1:0] MIN_TOP_FLOOR   = 5'd2;
    localparam logic [FLOOR_W-1:0] MAX_FLOOR       = FLOOR_W'(FLOORS);
    localparam logic [CNT_W-1:0]   MAX_COUNT       = '1;

    typedef struct packed {
        logic               new_request;
        logic [FLOOR_W-1:0] from_floor;
        logic [FLOOR_W-1:0] to_floor;
    } t_req;

    typedef struct packed {
        logic [FLOOR_W-1:0] car_floor;
        logic               going_up;
        logic [CNT_W-1:0]   rider_count;
        logic               boarded;
        logic [CNT_W-1:0]   alighted;
        logic               rejected;
        logic               idle;
        logic [TICK_W-1:0]  elapsed_ticks;
    } t_result;

    typedef struct packed {
        logic                  we;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } t_cfg_wr;

endpackage

// ===== rtl/core/ses_in_stage.sv =====
// Input register for hall requests with valid/stall handshake.
// Depends on ses_pkg.
`timescale 1ns / 1ps

module ses_in_stage
    import ses_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  t_req i_req,
    input  logic i_take,
    output logic o_valid,
    output t_req o_req
);

    logic r_valid;
    logic n_valid;
    t_req r_req;

    // accept whenever the held request leaves this cycle or none is held
    assign o_stall = r_valid && !i_take;
    assign n_valid = (i_valid && !o_stall) || (r_valid && !i_take);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= n_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_valid && !o_stall) begin
            r_req <= i_req;
        end
    end

    assign o_valid = r_valid;
    assign o_req   = r_req;

endmodule

// ===== rtl/core/ses_core.sv =====
// Scheduler state and one-tick service logic: request filing, alighting,
// boarding and the SCAN move. Holds the configuration registers. Uses ses_pkg.
`timescale 1ns / 1ps

module ses_core
    import ses_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  t_cfg_wr i_cfg,
    input  logic    i_step,
    input  t_req    i_req,
    output t_result o_result
);

    logic [CNT_W-1:0]   r_capacity;
    logic [FLOOR_W-1:0] r_top_floor;
    logic [FLOOR_W-1:0] r_car_pos;
    logic               r_moving_up;
    logic [CNT_W-1:0]   r_load;
    logic [TICK_W-1:0]  r_ticks;
    logic [FLOORS-1:0]  r_hall_pending;
    logic [FLOOR_W-1:0] r_hall_dest [FLOORS];
    logic [CNT_W-1:0]   r_riders [FLOORS];

    logic [FLOOR_W-1:0] n_car_pos;
    logic               n_moving_up;
    logic [CNT_W-1:0]   n_load;
    logic [FLOORS-1:0]  n_hall_pending;
    logic [CNT_W-1:0]   n_riders [FLOORS];

    logic [FLOOR_W-1:0] top;
    logic [FLOOR_W-1:0] pos;
    logic [IDX_W-1:0]   pi;
    logic [IDX_W-1:0]   fi;
    logic [IDX_W-1:0]   di;
    logic               req_ok;
    logic               file_req;
    logic [FLOORS-1:0]  hp_filed;
    logic [CNT_W-1:0]   here_riders;
    logic [CNT_W-1:0]   gone;
    logic [CNT_W-1:0]   load_left;
    logic               board;
    logic [FLOOR_W-1:0] dest;
    logic               ride;
    logic [FLOORS-1:0]  busy;
    logic [FLOORS-1:0]  mask_above;
    logic [FLOORS-1:0]  mask_below;
    logic               any_busy;
    logic               ahead;

    always_comb begin
        top = r_top_floor;
        if (top < MIN_TOP_FLOOR) top = MIN_TOP_FLOOR;
        if (top > MAX_FLOOR)     top = MAX_FLOOR;
        pos = r_car_pos;
        if (pos < 5'd1)      pos = 5'd1;
        if (pos > MAX_FLOOR) pos = MAX_FLOOR;
    end

    assign pi = IDX_W'(pos - 5'd1);
    assign fi = IDX_W'(i_req.from_floor - 5'd1);

    // from and to are checked in range before the pending bit is trusted
    assign req_ok = i_req.from_floor >= 5'd1 && i_req.from_floor <= top
                 && i_req.to_floor >= 5'd1 && i_req.to_floor <= top
                 && i_req.from_floor != i_req.to_floor;
    assign file_req = i_req.new_request && req_ok && !r_hall_pending[fi];

    always_comb begin
        hp_filed = r_hall_pending;
        if (file_req) hp_filed[fi] = 1'b1;
    end

    assign here_riders = r_riders[pi];
    assign gone        = (here_riders > r_load) ? r_load : here_riders;
    assign load_left   = r_load - gone;
    assign board       = hp_filed[pi] && (load_left < r_capacity);
    // bypass a destination filed in this same tick
    assign dest = (file_req && i_req.from_floor == pos) ? i_req.to_floor : r_hall_dest[pi];
    assign ride = board && dest >= 5'd1 && dest <= MAX_FLOOR && dest != pos
               && load_left != MAX_COUNT;
    assign di   = IDX_W'(dest - 5'd1);

    always_comb begin
        n_hall_pending = hp_filed;
        if (board) n_hall_pending[pi] = 1'b0;
        for (int i = 0; i < FLOORS; i++) begin
            n_riders[i] = r_riders[i];
        end
        n_riders[pi] = '0;
        if (ride) n_riders[di] = r_riders[di] + 4'd1;
        n_load = ride ? load_left + 4'd1 : load_left;
        for (int i = 0; i < FLOORS; i++) begin
            busy[i] = n_hall_pending[i] || (n_riders[i] != '0);
        end
    end

    assign mask_below = (FLOORS'(1) << pi) - FLOORS'(1);
    assign mask_above = ~((FLOORS'(2) << pi) - FLOORS'(1));
    assign any_busy   = |busy;
    assign ahead      = r_moving_up ? |(busy & mask_above) : |(busy & mask_below);

    always_comb begin
        n_car_pos   = pos;
        n_moving_up = r_moving_up;
        if (ahead) begin
            n_car_pos = r_moving_up ? pos + 5'd1 : pos - 5'd1;
        end else if (any_busy) begin
            n_moving_up = ~r_moving_up;
        end
    end

    always_comb begin
        o_result.car_floor     = pos;
        o_result.going_up      = n_moving_up;
        o_result.rider_count   = n_load;
        o_result.boarded       = board;
        o_result.alighted      = gone;
        o_result.rejected      = i_req.new_request && !file_req;
        o_result.idle          = !any_busy;
        o_result.elapsed_ticks = r_ticks;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= RST_CAPACITY;
            r_top_floor    <= RST_TOP_FLOOR;
            r_car_pos      <= RST_START_FLOOR;
            r_moving_up    <= 1'b0;
            r_load         <= '0;
            r_ticks        <= '0;
            r_hall_pending <= '0;
            for (int i = 0; i < FLOORS; i++) begin
                r_riders[i] <= '0;
            end
        end else if (i_cfg.we) begin
            case (i_cfg.index)
                CFG_CAPACITY:    r_capacity  <= i_cfg.data[CNT_W-1:0];
                CFG_START_FLOOR: r_car_pos   <= i_cfg.data;
                CFG_TOP_FLOOR:   r_top_floor <= i_cfg.data;
                default: ;
            endcase
        end else if (i_step) begin
            r_car_pos      <= n_car_pos;
            r_moving_up    <= n_moving_up;
            r_load         <= n_load;
            r_ticks        <= r_ticks + 16'd1;
            r_hall_pending <= n_hall_pending;
            for (int i = 0; i < FLOORS; i++) begin
                r_riders[i] <= n_riders[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_step && file_req) begin
            r_hall_dest[fi] <= i_req.to_floor;
        end
    end

endmodule

// ===== rtl/core/ses_out_stage.sv =====
// Result register for one tick's outcome, valid/stall toward the consumer.
// Depends on ses_pkg.
`timescale 1ns / 1ps

module ses_out_stage
    import ses_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_load,
    input  t_result i_result,
    input  logic    i_stall,
    output logic    o_free,
    output logic    o_valid,
    output t_result o_result
);

    logic    r_valid;
    t_result r_result;

    assign o_free = !r_valid || !i_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (o_free) begin
            r_valid <= i_load;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_result <= i_result;
        end
    end

    assign o_valid  = r_valid;
    assign o_result = r_result;

endmodule

// ===== rtl/core/scan_elevator_scheduler.sv =====
// SCAN elevator scheduler, one request per tick. Each accepted request is one
// tick: it is held in an input register, serviced combinationally against the
// car state, and its result lands in an output register. One tick per clock is
// sustained while the consumer does not stall; the result is valid once the
// request has passed the input and output registers. While a result waits on a
// stalled consumer, the input register takes one more request and then stalls.
// Write the configuration (capacity, start floor, top floor) only while no
// request is in flight; writing the start floor also places the car there.
// Depends on ses_pkg, ses_in_stage, ses_core, ses_out_stage.
`timescale 1ns / 1ps

module scan_elevator_scheduler
    import ses_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_in_valid,
    output logic                  o_in_stall,
    input  logic                  i_new_request,
    input  logic [FLOOR_W-1:0]    i_from_floor,
    input  logic [FLOOR_W-1:0]    i_to_floor,
    output logic                  o_out_valid,
    input  logic                  i_out_stall,
    output logic [FLOOR_W-1:0]    o_car_floor,
    output logic                  o_going_up,
    output logic [CNT_W-1:0]      o_rider_count,
    output logic                  o_boarded,
    output logic [CNT_W-1:0]      o_alighted,
    output logic                  o_rejected,
    output logic                  o_idle,
    output logic [TICK_W-1:0]     o_elapsed_ticks
);

    t_req    in_req;
    t_req    held_req;
    logic    held_valid;
    logic    out_free;
    logic    step;
    t_cfg_wr cfg;
    t_result core_result;
    t_result out_result;

    assign in_req.new_request = i_new_request;
    assign in_req.from_floor  = i_from_floor;
    assign in_req.to_floor    = i_to_floor;

    assign cfg.we    = i_cfg_we;
    assign cfg.index = i_cfg_index;
    assign cfg.data  = i_cfg_data;

    // advance a held request when the result register can take it
    assign step = held_valid && out_free;

    ses_in_stage u_in (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (i_in_valid),
        .o_stall (o_in_stall),
        .i_req   (in_req),
        .i_take  (out_free),
        .o_valid (held_valid),
        .o_req   (held_req)
    );

    ses_core u_core (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg    (cfg),
        .i_step   (step),
        .i_req    (held_req),
        .o_result (core_result)
    );

    ses_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (step),
        .i_result (core_result),
        .i_stall  (i_out_stall),
        .o_free   (out_free),
        .o_valid  (o_out_valid),
        .o_result (out_result)
    );

    assign o_car_floor     = out_result.car_floor;
    assign o_going_up      = out_result.going_up;
    assign o_rider_count   = out_result.rider_count;
    assign o_boarded       = out_result.boarded;
    assign o_alighted      = out_result.alighted;
    assign o_rejected      = out_result.rejected;
    assign o_idle          = out_result.idle;
    assign o_elapsed_ticks = out_result.elapsed_ticks;

endmodule

// ===== tb/sv/scan_elevator_scheduler_tb.sv =====
// Self-checking testbench for scan_elevator_scheduler: random and directed ticks
// against a built-in SCAN car predictor, with idling on both handshake sides.
// Depends on ses_pkg and the scan_elevator_scheduler RTL.
`timescale 1ns / 1ps

module scan_elevator_scheduler_tb;
    import ses_pkg::*;

    localparam int CLK_PERIOD  = 8;
    localparam int QUIET_LIMIT = 2000;
    localparam int MAX_REPORTS = 200;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  i_cfg_index = '0;
    logic [CFG_DATA_W-1:0] i_cfg_data = '0;
    logic                  i_in_valid = 1'b0;
    logic                  o_in_stall;
    logic                  i_new_request = 1'b0;
    logic [FLOOR_W-1:0]    i_from_floor = '0;
    logic [FLOOR_W-1:0]    i_to_floor = '0;
    logic                  o_out_valid;
    logic                  i_out_stall = 1'b0;
    logic [FLOOR_W-1:0]    o_car_floor;
    logic                  o_going_up;
    logic [CNT_W-1:0]      o_rider_count;
    logic                  o_boarded;
    logic [CNT_W-1:0]      o_alighted;
    logic                  o_rejected;
    logic                  o_idle;
    logic [TICK_W-1:0]     o_elapsed_ticks;

    scan_elevator_scheduler u_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_we        (i_cfg_we),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_in_valid      (i_in_valid),
        .o_in_stall      (o_in_stall),
        .i_new_request   (i_new_request),
        .i_from_floor    (i_from_floor),
        .i_to_floor      (i_to_floor),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_car_floor     (o_car_floor),
        .o_going_up      (o_going_up),
        .o_rider_count   (o_rider_count),
        .o_boarded       (o_boarded),
        .o_alighted      (o_alighted),
        .o_rejected      (o_rejected),
        .o_idle          (o_idle),
        .o_elapsed_ticks (o_elapsed_ticks)
    );

    always #(CLK_PERIOD / 2) i_clk = ~i_clk;

    // predicted car state and register copies
    logic [CNT_W-1:0]   cfg_capacity;
    logic [FLOOR_W-1:0] cfg_top;
    logic [FLOOR_W-1:0] car_at;
    logic               heading_up;
    logic [CNT_W-1:0]   riders_on;
    logic [TICK_W-1:0]  tick_no;
    logic               hall_call [0:31];
    logic [FLOOR_W-1:0] hall_to   [0:31];
    logic [CNT_W-1:0]   bound_for [0:31];

    t_req    pending_ticks [$];
    t_result due_results   [$];

    int  ticks_sent = 0;
    int  errors = 0;
    int  send_gap = 0;
    int  recv_gap = 0;
    int  quiet_cycles = 0;
    bit  calm = 1'b0;

    function automatic logic floor_waiting(int lo, int hi);
        for (int f = lo; f <= hi && f <= FLOORS; f++) begin
            if (f >= 1 && (hall_call[f] || bound_for[f] != '0))
                return 1'b1;
        end
        return 1'b0;
    endfunction

    function automatic t_result service_tick(t_req rq);
        int      top;
        int      pos;
        int      f;
        int      t;
        int      gone;
        int      d;
        logic    ahead;
        logic    anything;
        t_result r;
        r = '0;
        top = cfg_top;
        if (top < 2) top = 2;
        if (top > FLOORS) top = FLOORS;
        pos = car_at;
        if (pos < 1) pos = 1;
        if (pos > FLOORS) pos = FLOORS;

        // register the hall request before servicing the floor
        if (rq.new_request) begin
            f = rq.from_floor;
            t = rq.to_floor;
            if (f < 1 || f > top || t < 1 || t > top || f == t || hall_call[f]) begin
                r.rejected = 1'b1;
            end else begin
                hall_call[f] = 1'b1;
                hall_to[f] = rq.to_floor;
            end
        end

        gone = bound_for[pos];
        if (gone > riders_on) gone = riders_on;
        riders_on = riders_on - CNT_W'(gone);
        bound_for[pos] = '0;

        if (hall_call[pos] && riders_on < cfg_capacity) begin
            d = hall_to[pos];
            hall_call[pos] = 1'b0;
            if (d >= 1 && d <= FLOORS && d != pos && riders_on < MAX_COUNT) begin
                bound_for[d] = bound_for[d] + 1'b1;
                riders_on = riders_on + 1'b1;
            end
            r.boarded = 1'b1;
        end
        r.car_floor = FLOOR_W'(pos);

        anything = floor_waiting(1, FLOORS);
        ahead = heading_up ? floor_waiting(pos + 1, FLOORS) : floor_waiting(1, pos - 1);
        if (ahead)
            pos = heading_up ? pos + 1 : pos - 1;
        else if (anything)
            heading_up = !heading_up;
        car_at = FLOOR_W'(pos);

        r.going_up = heading_up;
        r.rider_count = riders_on;
        r.alighted = CNT_W'(gone);
        r.idle = !anything;
        r.elapsed_ticks = tick_no;
        tick_no = tick_no + 1'b1;
        return r;
    endfunction

    // sender: hold the payload while stalled, advance on acceptance
    always @(posedge i_clk) begin
        t_req rq;
        if (i_rst_n) begin
            if (i_in_valid && !o_in_stall) begin
                rq = {i_new_request, i_from_floor, i_to_floor};
                due_results.push_back(service_tick(rq));
                ticks_sent++;
                if (!calm && $urandom_range(0, 7) == 0)
                    send_gap = $urandom_range(1, 10);
            end
            if (!i_in_valid || !o_in_stall) begin
                if (send_gap > 0 || pending_ticks.size() == 0) begin
                    if (send_gap > 0) send_gap--;
                    i_in_valid <= 1'b0;
                end else begin
                    rq = pending_ticks.pop_front();
                    i_in_valid    <= 1'b1;
                    i_new_request <= rq.new_request;
                    i_from_floor  <= rq.from_floor;
                    i_to_floor    <= rq.to_floor;
                end
            end
        end
    end

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            errors++;
            if (errors <= MAX_REPORTS)
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // receiver: compare each result with the oldest prediction
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        if (i_rst_n) begin
            if (o_out_valid && !i_out_stall) begin
                got = {o_car_floor, o_going_up, o_rider_count, o_boarded, o_alighted,
                       o_rejected, o_idle, o_elapsed_ticks};
                if (due_results.size() == 0) begin
                    errors++;
                    $display("%0t: unexpected result, expected none, actual %p", $time, got);
                end else begin
                    want = due_results.pop_front();
                    check_field("car_floor", want.car_floor, got.car_floor);
                    check_field("going_up", want.going_up, got.going_up);
                    check_field("rider_count", want.rider_count, got.rider_count);
                    check_field("boarded", want.boarded, got.boarded);
                    check_field("alighted", want.alighted, got.alighted);
                    check_field("rejected", want.rejected, got.rejected);
                    check_field("idle", want.idle, got.idle);
                    check_field("elapsed_ticks", want.elapsed_ticks, got.elapsed_ticks);
                end
            end
            if (recv_gap > 0) begin
                recv_gap--;
                i_out_stall <= 1'b1;
            end else if (!calm && $urandom_range(0, 7) == 0) begin
                recv_gap = $urandom_range(0, 9);
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= 1'b0;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (i_in_valid && !o_in_stall) || (o_out_valid && !i_out_stall))
            quiet_cycles = 0;
        else
            quiet_cycles++;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic push_tick(bit req, int from_f, int to_f);
        pending_ticks.push_back({req, FLOOR_W'(from_f), FLOOR_W'(to_f)});
    endtask

    // mostly well-formed requests, some malformed, some empty ticks
    task automatic push_random(int count, int req_pct);
        int   top;
        int   from_f;
        int   to_f;
        int   pick;
        top = cfg_top;
        if (top < 2) top = 2;
        if (top > FLOORS) top = FLOORS;
        repeat (count) begin
            pick = $urandom_range(0, 99);
            from_f = $urandom_range(0, 31);
            to_f = $urandom_range(0, 31);
            if (pick < req_pct && $urandom_range(0, 9) != 0) begin
                from_f = $urandom_range(1, top);
                to_f = $urandom_range(1, top - 1);
                if (to_f >= from_f) to_f++;
            end
            push_tick(pick < req_pct, from_f, to_f);
        end
    endtask

    // sample at the falling edge so every update of the rising edge has settled
    task automatic drain();
        do @(negedge i_clk);
        while (pending_ticks.size() != 0 || i_in_valid || due_results.size() != 0);
        repeat (4) @(negedge i_clk);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        case (idx)
            CFG_CAPACITY: cfg_capacity = val[CNT_W-1:0];
            CFG_START_FLOOR: begin
                car_at = val;
            end
            CFG_TOP_FLOOR: cfg_top = val;
            default: ;
        endcase
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
    endtask

    task automatic configure(int cap_v, int start_v, int top_v);
        write_reg(CFG_CAPACITY, CFG_DATA_W'(cap_v));
        write_reg(CFG_START_FLOOR, CFG_DATA_W'(start_v));
        write_reg(CFG_TOP_FLOOR, CFG_DATA_W'(top_v));
    endtask

    int phase_cap   [8] = '{1, 15, 4, 0, 2, 7, 15, 3};
    int phase_start [8] = '{1, 16, 8, 0, 5, 31, 1, 12};
    int phase_top   [8] = '{16, 16, 10, 0, 1, 12, 31, 2};
    int phase_load  [8] = '{80, 60, 30, 70, 50, 90, 85, 40};

    initial begin
        cfg_capacity = RST_CAPACITY;
        cfg_top = RST_TOP_FLOOR;
        car_at = RST_START_FLOOR;
        heading_up = 1'b0;
        riders_on = '0;
        tick_no = '0;
        for (int f = 0; f < 32; f++) begin
            hall_call[f] = 1'b0;
            hall_to[f] = '0;
            bound_for[f] = '0;
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // reset settings: empty ticks, malformed and duplicate requests
        push_tick(0, 0, 0);
        push_tick(0, 31, 31);
        push_tick(1, 0, 5);
        push_tick(1, 5, 0);
        push_tick(1, 11, 2);
        push_tick(1, 2, 11);
        push_tick(1, 3, 3);
        push_tick(1, 31, 31);
        push_tick(1, 1, 10);
        push_tick(1, 5, 2);
        push_tick(1, 5, 3);
        push_tick(1, 10, 1);
        repeat (3) push_tick(0, 0, 0);
        drain();

        // zero capacity through the masked upper data bit, car above the top
        configure(16, 31, 31);
        push_tick(1, 16, 1);
        push_tick(1, 1, 16);
        push_tick(1, 16, 2);
        push_tick(1, 17, 1);
        repeat (2) push_tick(0, 0, 0);
        drain();

        // car below floor one, top floor clamped up to two
        configure(1, 0, 1);
        push_tick(1, 2, 1);
        push_tick(1, 1, 2);
        push_tick(1, 1, 3);
        repeat (2) push_tick(0, 0, 0);
        drain();

        for (int p = 0; p < 8; p++) begin
            configure(phase_cap[p], phase_start[p], phase_top[p]);
            push_random(160, phase_load[p]);
            drain();
        end

        // sparse traffic: the car settles and idles between requests
        configure(4, 9, 16);
        push_random(50, 2);
        drain();

        calm = 1'b1;
        configure(3, 16, 14);
        push_random(300, 75);
        drain();

        if (errors == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
